/* rtl/core/rlcrw_pkg.sv */
`timescale 1ns / 1ps
// Package for the receive window block: shared types, field widths and codes.
// It has no dependencies and is used by every module of the block.
package rlcrw_pkg;

  localparam int SEQ_SPACE_DEF  = 128;
  localparam int MAX_WINDOW_DEF = 64;

  localparam int FUNC_W = 2;
  localparam int BN_W   = 7;
  localparam int CNT_W  = 7;
  localparam int CFG_W  = 7;
  localparam int MAP_W  = 64;

  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int QC_W    = $clog2(Q_DEPTH + 1);

  localparam logic [CFG_W-1:0] WINDOW_RESET = CFG_W'(64);

  localparam logic [FUNC_W-1:0] FN_RECEIVE    = 2'd0;
  localparam logic [FUNC_W-1:0] FN_INVALIDATE = 2'd1;
  localparam logic [FUNC_W-1:0] FN_BITMAP     = 2'd2;
  localparam logic [FUNC_W-1:0] FN_CLEAR      = 2'd3;

  typedef enum logic [3:0] {
    OP_RECEIVE    = 4'b0001,
    OP_INVALIDATE = 4'b0010,
    OP_BITMAP     = 4'b0100,
    OP_CLEAR      = 4'b1000
  } op_t;

  typedef enum logic [1:0] {
    ST_INVALID  = 2'd0,
    ST_RECEIVED = 2'd1,
    ST_MISSING  = 2'd2
  } blkst_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [BN_W-1:0]   block_number;
  } in_item_t;

  typedef struct packed {
    logic [CNT_W-1:0] delivered_count;
    logic             was_received;
    logic [MAP_W-1:0] receive_bitmap;
    logic [BN_W-1:0]  receive_pointer;
    logic [BN_W-1:0]  window_start;
  } out_item_t;

  typedef struct packed {
    op_t             op;
    logic [BN_W-1:0] block_number;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_req_t;

  typedef struct packed {
    logic take;
    logic init_busy;
  } back_stat_t;

endpackage

/* rtl/core/rlcrw_front.sv */
`timescale 1ns / 1ps
// Front part: accepts requests, decodes the function code and queues commands.
// Depends on rlcrw_pkg.
module rlcrw_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  rlcrw_pkg::in_item_t   in_item,
  output rlcrw_pkg::cmd_req_t   q_req,
  input  rlcrw_pkg::back_stat_t back_stat
);
  import rlcrw_pkg::*;

  cmd_t            q_mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r;
  logic [Q_AW-1:0] wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r;
  logic [Q_AW-1:0] rd_ptr_nxt;
  logic [QC_W-1:0] cnt_r;
  logic [QC_W-1:0] cnt_nxt;
  logic            push;
  logic            pop;
  cmd_t            dec_cmd;

  always_comb begin
    dec_cmd.block_number = in_item.block_number;
    unique case (in_item.func)
      FN_RECEIVE:    dec_cmd.op = OP_RECEIVE;
      FN_INVALIDATE: dec_cmd.op = OP_INVALIDATE;
      FN_BITMAP:     dec_cmd.op = OP_BITMAP;
      FN_CLEAR:      dec_cmd.op = OP_CLEAR;
      default:       dec_cmd.op = OP_CLEAR;
    endcase
  end

  assign in_stall = (cnt_r == QC_W'(Q_DEPTH)) || back_stat.init_busy;
  assign push     = in_valid && !in_stall;
  assign pop      = back_stat.take;

  assign q_req.valid = (cnt_r != '0);
  assign q_req.cmd   = q_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + Q_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + Q_AW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + QC_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= dec_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    back_stat.take |-> (cnt_r != '0))
    else $error("command taken from an empty queue");
`endif

endmodule

/* rtl/core/rlcrw_back.sv */
`timescale 1ns / 1ps
// Back part: block state store, pointer sequencer and result register.
// Depends on rlcrw_pkg and takes commands from rlcrw_front.
module rlcrw_back #(
  parameter int SEQ_SPACE  = rlcrw_pkg::SEQ_SPACE_DEF,
  parameter int MAX_WINDOW = rlcrw_pkg::MAX_WINDOW_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [rlcrw_pkg::CFG_W-1:0]     window_size,
  input  rlcrw_pkg::cmd_req_t             q_req,
  output rlcrw_pkg::back_stat_t           back_stat,
  output logic                            out_valid,
  input  logic                            out_stall,
  output rlcrw_pkg::out_item_t            out_item
);
  import rlcrw_pkg::*;

  localparam int PTR_W = $clog2(SEQ_SPACE);
  localparam logic [PTR_W-1:0] HALF     = PTR_W'(SEQ_SPACE / 2);
  localparam logic [PTR_W-1:0] LAST     = PTR_W'(SEQ_SPACE - 1);
  localparam logic [CFG_W-1:0] MAX_WS   = CFG_W'(MAX_WINDOW);
  localparam logic [CNT_W-1:0] CNT_SAT  = '1;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_CLR    = 9'b000000010,
    S_RX     = 9'b000000100,
    S_MISS   = 9'b000001000,
    S_WALK0  = 9'b000010000,
    S_WALK   = 9'b000100000,
    S_INV_WR = 9'b001000000,
    S_MAP    = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  blkst_t            mem [SEQ_SPACE];
  blkst_t            mem_q_r;
  logic              mem_we;
  logic [PTR_W-1:0]  mem_waddr;
  blkst_t            mem_wdata;
  logic [PTR_W-1:0]  mem_raddr;

  state_t            state_r;
  state_t            state_nxt;
  logic              init_r;
  logic              init_nxt;
  cmd_t              cmd_r;
  cmd_t              cmd_nxt;
  logic [PTR_W-1:0]  recv_r;
  logic [PTR_W-1:0]  recv_nxt;
  logic [PTR_W-1:0]  start_r;
  logic [PTR_W-1:0]  start_nxt;
  logic [PTR_W-1:0]  miss_r;
  logic [PTR_W-1:0]  miss_nxt;
  logic [PTR_W-1:0]  addr_r;
  logic [PTR_W-1:0]  addr_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  cnt_nxt;
  logic [CFG_W-1:0]  iss_r;
  logic [CFG_W-1:0]  iss_nxt;
  logic              rdv_r;
  logic              rdv_nxt;
  logic              was_r;
  logic              was_nxt;
  logic [MAP_W-1:0]  map_r;
  logic [MAP_W-1:0]  map_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  out_item_t         out_r;
  out_item_t         out_nxt;

  logic [CFG_W-1:0]  ws;
  logic [PTR_W-1:0]  bn_ext;
  logic [PTR_W-1:0]  fwd_gap;

  assign ws      = (window_size > MAX_WS) ? MAX_WS : window_size;
  assign bn_ext  = PTR_W'(cmd_r.block_number);
  assign fwd_gap = bn_ext + PTR_W'(1) - recv_r;

  assign back_stat.take      = (state_r == S_IDLE) && q_req.valid;
  assign back_stat.init_busy = init_r;

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  always_comb begin
    state_nxt     = state_r;
    init_nxt      = init_r;
    cmd_nxt       = cmd_r;
    recv_nxt      = recv_r;
    start_nxt     = start_r;
    miss_nxt      = miss_r;
    addr_nxt      = addr_r;
    cnt_nxt       = cnt_r;
    iss_nxt       = iss_r;
    rdv_nxt       = 1'b0;
    was_nxt       = was_r;
    map_nxt       = map_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    mem_we        = 1'b0;
    mem_waddr     = addr_r;
    mem_wdata     = ST_INVALID;
    mem_raddr     = start_r;

    unique case (state_r)
      S_IDLE: begin
        if (q_req.valid) begin
          cmd_nxt   = q_req.cmd;
          cnt_nxt   = '0;
          was_nxt   = 1'b0;
          map_nxt   = '0;
          iss_nxt   = '0;
          mem_raddr = PTR_W'(q_req.cmd.block_number);
          unique case (q_req.cmd.op)
            OP_RECEIVE: begin
              state_nxt = S_RX;
            end
            OP_INVALIDATE: begin
              state_nxt = S_INV_WR;
            end
            OP_BITMAP: begin
              addr_nxt  = recv_r - PTR_W'(1);
              state_nxt = S_MAP;
            end
            OP_CLEAR: begin
              addr_nxt  = '0;
              state_nxt = S_CLR;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = addr_r;
        mem_wdata = ST_INVALID;
        addr_nxt  = addr_r + PTR_W'(1);
        if (addr_r == LAST) begin
          if (init_r) begin
            init_nxt  = 1'b0;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_RX: begin
        mem_we    = 1'b1;
        mem_waddr = bn_ext;
        mem_wdata = ST_RECEIVED;
        if ((fwd_gap != '0) && (fwd_gap < HALF)) begin
          miss_nxt  = fwd_gap - PTR_W'(1);
          state_nxt = S_MISS;
        end else begin
          state_nxt = S_WALK0;
        end
      end
      S_MISS: begin
        recv_nxt = recv_r + PTR_W'(1);
        if (miss_r != '0) begin
          mem_we    = 1'b1;
          mem_waddr = recv_r;
          mem_wdata = ST_MISSING;
          miss_nxt  = miss_r - PTR_W'(1);
        end else begin
          mem_raddr = start_r;
          state_nxt = S_WALK;
        end
      end
      S_WALK0: begin
        mem_raddr = start_r;
        state_nxt = S_WALK;
      end
      S_WALK: begin
        if ((start_r != recv_r) && (mem_q_r == ST_RECEIVED)) begin
          start_nxt = start_r + PTR_W'(1);
          mem_raddr = start_r + PTR_W'(1);
          cnt_nxt   = (cnt_r != CNT_SAT) ? cnt_r + CNT_W'(1) : cnt_r;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_INV_WR: begin
        was_nxt   = (mem_q_r == ST_RECEIVED);
        mem_we    = 1'b1;
        mem_waddr = bn_ext;
        mem_wdata = ST_MISSING;
        state_nxt = S_DONE;
      end
      S_MAP: begin
        mem_raddr = addr_r;
        if (rdv_r) begin
          map_nxt = {map_r[MAP_W-2:0], (mem_q_r == ST_RECEIVED)};
        end
        if (iss_r != ws) begin
          iss_nxt  = iss_r + CFG_W'(1);
          addr_nxt = addr_r - PTR_W'(1);
          rdv_nxt  = 1'b1;
        end else if (!rdv_r) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt.delivered_count = cnt_r;
          out_nxt.was_received    = was_r;
          out_nxt.receive_bitmap  = map_r;
          out_nxt.receive_pointer = recv_r[BN_W-1:0];
          out_nxt.window_start    = start_r[BN_W-1:0];
          out_valid_nxt           = 1'b1;
          state_nxt               = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_q_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    miss_r <= miss_nxt;
    cnt_r  <= cnt_nxt;
    was_r  <= was_nxt;
    map_r  <= map_nxt;
    out_r  <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      init_r      <= 1'b1;
      addr_r      <= '0;
      recv_r      <= '0;
      start_r     <= '0;
      iss_r       <= '0;
      rdv_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_r      <= init_nxt;
      addr_r      <= addr_nxt;
      recv_r      <= recv_nxt;
      start_r     <= start_nxt;
      iss_r       <= iss_nxt;
      rdv_r       <= rdv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_recv_moves_in_miss: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(recv_r) |-> $past(state_r == S_MISS))
    else $error("receive pointer moved outside the skip sequence");
  a_walk_stops_at_recv: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) && (start_r == recv_r) |=> $stable(start_r))
    else $error("window start walked past the receive pointer");
  a_no_result_in_init: assert property (@(posedge clk) disable iff (!rst_n)
    init_r |-> !out_valid_r)
    else $error("result presented during the initial clearing pass");
  a_map_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MAP) |-> (iss_r <= ws))
    else $error("bitmap read count exceeds the window size");
`endif

endmodule

/* rtl/core/rlc_uplink_receive_window_top.sv */
`timescale 1ns / 1ps
// Throughput: one request at a time in the back part, up to two queued in front.
// Each command runs as a state sequence: receive marks the block and any skipped blocks, then
// walks the window start over received blocks; invalidate rewrites one entry; bitmap reads the
// window below the receive pointer; clear writes every entry. The state memory has one write and
// one read port; the walks touch one entry per cycle. Synchronous active-low reset; afterwards a
// pass clears the state memory, with in_stall high, while configuration writes are taken.
module rlc_uplink_receive_window_top #(
  parameter int SEQ_SPACE  = rlcrw_pkg::SEQ_SPACE_DEF,
  parameter int MAX_WINDOW = rlcrw_pkg::MAX_WINDOW_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  rlcrw_pkg::in_item_t         in_item,
  output logic                        out_valid,
  input  logic                        out_stall,
  output rlcrw_pkg::out_item_t        out_item,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [rlcrw_pkg::CFG_W-1:0] cfg_data
);
  import rlcrw_pkg::*;

  logic [CFG_W-1:0] win_r;
  logic [CFG_W-1:0] win_nxt;
  cmd_req_t         q_req;
  back_stat_t       back_stat;

  assign cfg_ready = 1'b1;
  assign win_nxt   = (cfg_valid && cfg_ready) ? cfg_data : win_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= WINDOW_RESET;
    end else begin
      win_r <= win_nxt;
    end
  end

  rlcrw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .q_req     (q_req),
    .back_stat (back_stat)
  );

  rlcrw_back #(
    .SEQ_SPACE  (SEQ_SPACE),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .window_size (win_r),
    .q_req       (q_req),
    .back_stat   (back_stat),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item)
  );

endmodule

/* tb/tb_rlc_uplink_receive_window_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for rlc_uplink_receive_window_top: a directed table, then random
// request streams over several window sizes and idle patterns, each result checked against typed
// values or a local predictor of the receive window. Depends on rlcrw_pkg and the block's RTL.
module tb_rlc_uplink_receive_window_top;
  import rlcrw_pkg::*;

  localparam int SEQ = SEQ_SPACE_DEF;
  localparam int MAXW = MAX_WINDOW_DEF;
  localparam int LONG_HOLD = 200;
  localparam int TAIL_CYCLES = SEQ + 80;
  localparam int RAND_PER_PHASE = 140;
  localparam int PHASES = 8;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t res;
  } stim_row_t;

  typedef struct {
    bit        typed;
    out_item_t res;
  } req_note_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  in_item_t         in_item;
  logic             out_valid;
  logic             out_stall;
  out_item_t        out_item;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data;

  blkst_t           blk_state [SEQ];
  logic [BN_W-1:0]  rx_ptr;
  logic [BN_W-1:0]  win_start;
  logic [CFG_W-1:0] bitmap_len;

  req_note_t        req_notes [$];
  out_item_t        results_due [$];
  stim_row_t        stim_table [$];
  int               errors;
  int               send_idle_pct;
  int               recv_stall_pct;
  bit               long_hold_req;
  logic [BN_W-1:0]  cursor;

  rlc_uplink_receive_window_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic out_item_t predict_window(in_item_t it);
    out_item_t       r;
    logic [BN_W-1:0] bn;
    logic [BN_W-1:0] gap;
    logic [BN_W-1:0] idx;
    int              count;
    int              len;
    r = '0;
    bn = it.block_number;
    case (it.func)
      FN_RECEIVE: begin
        blk_state[bn] = ST_RECEIVED;
        gap = bn + BN_W'(1) - rx_ptr;
        if (gap < BN_W'(SEQ / 2)) begin
          while (gap != 0) begin
            gap = gap - BN_W'(1);
            if (gap != 0) blk_state[rx_ptr] = ST_MISSING;
            rx_ptr = rx_ptr + BN_W'(1);
          end
        end
        count = 0;
        while (win_start != rx_ptr && blk_state[win_start] == ST_RECEIVED) begin
          win_start = win_start + BN_W'(1);
          count++;
        end
        r.delivered_count = (count > 127) ? CNT_W'(127) : CNT_W'(count);
      end
      FN_INVALIDATE: begin
        r.was_received = (blk_state[bn] == ST_RECEIVED);
        blk_state[bn] = ST_MISSING;
      end
      FN_BITMAP: begin
        len = (bitmap_len > MAXW) ? MAXW : int'(bitmap_len);
        for (int i = 0; i < len; i++) begin
          idx = rx_ptr - BN_W'(1) - BN_W'(i);
          if (blk_state[idx] == ST_RECEIVED) r.receive_bitmap[len - 1 - i] = 1'b1;
        end
      end
      default: begin
        foreach (blk_state[k]) blk_state[k] = ST_INVALID;
      end
    endcase
    r.receive_pointer = rx_ptr;
    r.window_start = win_start;
    return r;
  endfunction

  function automatic stim_row_t pred_row(logic [FUNC_W-1:0] fn, int bn);
    stim_row_t s;
    s.item.func = fn;
    s.item.block_number = BN_W'(bn);
    s.typed = 1'b0;
    s.res = '0;
    return s;
  endfunction

  function automatic stim_row_t typed_row(logic [FUNC_W-1:0] fn, int bn, int cnt, bit was,
                                          int rp, int ws);
    stim_row_t s;
    s = pred_row(fn, bn);
    s.typed = 1'b1;
    s.res.delivered_count = CNT_W'(cnt);
    s.res.was_received = was;
    s.res.receive_bitmap = '0;
    s.res.receive_pointer = BN_W'(rp);
    s.res.window_start = BN_W'(ws);
    return s;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : result_monitor
    req_note_t note;
    out_item_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        want = predict_window(in_item);
        note = req_notes.pop_front();
        results_due.push_back(note.typed ? note.res : want);
      end
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          $error("result arrived with no request outstanding");
          errors++;
        end else begin
          want = results_due.pop_front();
          check_field("delivered_count", 64'(want.delivered_count),
                      64'(out_item.delivered_count));
          check_field("was_received", 64'(want.was_received), 64'(out_item.was_received));
          check_field("receive_bitmap", want.receive_bitmap, out_item.receive_bitmap);
          check_field("receive_pointer", 64'(want.receive_pointer),
                      64'(out_item.receive_pointer));
          check_field("window_start", 64'(want.window_start), 64'(out_item.window_start));
        end
      end
    end
  end

  initial begin : receiver
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic send_req(in_item_t it, bit typed, out_item_t res);
    req_note_t note;
    note.typed = typed;
    note.res = res;
    req_notes.push_back(note);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (req_notes.size() != 0 || results_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_window(logic [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    bitmap_len = value;
  endtask

  initial begin : stimulus
    in_item_t         it;
    int               r;
    logic [CFG_W-1:0] phase_window [PHASES];
    errors = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    long_hold_req = 1'b0;
    cursor = '0;
    foreach (blk_state[k]) blk_state[k] = ST_INVALID;
    rx_ptr = '0;
    win_start = '0;
    bitmap_len = WINDOW_RESET;
    phase_window = '{CFG_W'(64), CFG_W'(1), CFG_W'(127), CFG_W'(0),
                     CFG_W'(17), CFG_W'(64), CFG_W'(33), CFG_W'($urandom_range(2, 63))};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    write_window(WINDOW_RESET);

    stim_table.push_back(typed_row(FN_BITMAP, 0, 0, 1'b0, 0, 0));
    stim_table.push_back(typed_row(FN_RECEIVE, 0, 1, 1'b0, 1, 1));
    stim_table.push_back(typed_row(FN_RECEIVE, 127, 0, 1'b0, 1, 1));
    stim_table.push_back(typed_row(FN_INVALIDATE, 127, 0, 1'b1, 1, 1));
    stim_table.push_back(typed_row(FN_INVALIDATE, 127, 0, 1'b0, 1, 1));
    stim_table.push_back(typed_row(FN_INVALIDATE, 5, 0, 1'b0, 1, 1));
    stim_table.push_back(typed_row(FN_RECEIVE, 64, 0, 1'b0, 1, 1));
    stim_table.push_back(typed_row(FN_RECEIVE, 63, 0, 1'b0, 64, 1));
    stim_table.push_back(pred_row(FN_BITMAP, 127));
    stim_table.push_back(pred_row(FN_RECEIVE, 1));
    stim_table.push_back(pred_row(FN_RECEIVE, 65));
    stim_table.push_back(pred_row(FN_BITMAP, 85));
    stim_table.push_back(pred_row(FN_CLEAR, 42));
    stim_table.push_back(pred_row(FN_BITMAP, 0));
    stim_table.push_back(pred_row(FN_RECEIVE, 66));
    stim_table.push_back(pred_row(FN_RECEIVE, 127));
    stim_table.push_back(pred_row(FN_INVALIDATE, 66));
    stim_table.push_back(pred_row(FN_INVALIDATE, 127));
    stim_table.push_back(pred_row(FN_BITMAP, 3));
    stim_table.push_back(pred_row(FN_RECEIVE, 0));
    stim_table.push_back(pred_row(FN_CLEAR, 127));
    foreach (stim_table[k]) send_req(stim_table[k].item, stim_table[k].typed, stim_table[k].res);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      write_window(phase_window[ph]);
      case (ph % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 68;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 68;
        end
        default: begin
          send_idle_pct = 26;
          recv_stall_pct = 26;
        end
      endcase
      if (ph == 0) long_hold_req = 1'b1;
      cursor = rx_ptr;
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        if (ph == 3 && n == RAND_PER_PHASE / 2) drain();
        r = $urandom_range(99);
        it.func = FN_RECEIVE;
        it.block_number = BN_W'($urandom);
        if (r < 55) begin
          if ($urandom_range(99) < 15) cursor = cursor + BN_W'($urandom_range(2, 8));
          it.block_number = cursor;
          cursor = cursor + BN_W'(1);
        end else if (r < 70) begin
          it.block_number = cursor - BN_W'($urandom_range(1, 12));
        end else if (r < 80) begin
          it.func = FN_BITMAP;
        end else if (r < 87) begin
          it.func = FN_INVALIDATE;
          it.block_number = cursor - BN_W'($urandom_range(0, 10));
        end else if (r < 89) begin
          it.func = FN_CLEAR;
        end else if (r < 92) begin
          it.block_number = cursor + BN_W'($urandom_range(64, 127));
        end else if (r < 94) begin
          cursor = cursor + BN_W'($urandom_range(20, 62));
          it.block_number = cursor;
          cursor = cursor + BN_W'(1);
        end else begin
          it.func = FUNC_W'($urandom);
        end
        send_req(it, 1'b0, '0);
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
